[rtl/gtg_pkg.sv]
// Shared types, constants and the arctangent table of the go-to-goal controller.
package gtg_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_X     = 3'd0,
    REG_GOAL_Y     = 3'd1,
    REG_TOLERANCE  = 3'd2,
    REG_DIST_GAIN  = 3'd3,
    REG_ANGLE_GAIN = 3'd4,
    REG_SPEED_LIM  = 3'd5,
    REG_TURN_LIM   = 3'd6,
    REG_RAMP_STEPS = 3'd7
  } reg_idx_t;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

  typedef struct packed {
    logic       load;
    logic       sq_x;
    logic       sq_y;
    logic       root;
    logic [4:0] step;
    logic       distance;
    logic       speed;
    logic       clamp;
    logic       div;
    logic       err;
    logic       ang;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic arrived;
    logic ramp;
  } dp_status_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021688;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/gtg_pose_if.sv]
// Pose sample channel: position and heading with valid and ready.
interface gtg_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  modport source(output valid, pos_x, pos_y, heading, input ready);
  modport sink(input valid, pos_x, pos_y, heading, output ready);
endinterface

[rtl/gtg_result_if.sv]
// Velocity command channel: linear and angular commands with valid and ready.
interface gtg_result_if;
  logic               valid;
  logic               ready;
  logic [14:0]        lin_cmd;
  logic signed [15:0] ang_cmd;
  logic               arrived;
  modport source(output valid, lin_cmd, ang_cmd, arrived, input ready);
  modport sink(input valid, lin_cmd, ang_cmd, arrived, output ready);
endinterface

[rtl/gtg_cfg_if.sv]
// Configuration write channel: register index and write data with valid and ready.
interface gtg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/gtg_ctrl.sv]
// Sequencer that steps the controller datapath through one pose sample.
module gtg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_free,
  input  gtg_pkg::dp_status_t status,
  output gtg_pkg::dp_cmd_t   cmd
);
  import gtg_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SQX   = 11'b00000000010,
    S_SQY   = 11'b00000000100,
    S_ROOT  = 11'b00000001000,
    S_DIST  = 11'b00000010000,
    S_SPEED = 11'b00000100000,
    S_CLAMP = 11'b00001000000,
    S_DIV   = 11'b00010000000,
    S_ERR   = 11'b00100000000,
    S_ANG   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.step   = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQX;
        end
      end
      S_SQX: begin
        cmd.sq_x   = 1'b1;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y   = 1'b1;
        cnt_next   = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) begin
          state_next = S_DIST;
        end
      end
      S_DIST: begin
        cmd.distance = 1'b1;
        state_next   = S_SPEED;
      end
      S_SPEED: begin
        if (status.arrived) begin
          state_next = S_OUT;
        end else begin
          cmd.speed  = 1'b1;
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        cnt_next  = '0;
        if (status.ramp) begin
          state_next = S_DIV;
        end else begin
          state_next = S_ERR;
        end
      end
      S_DIV: begin
        cmd.div  = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd30) begin
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err    = 1'b1;
        state_next = S_ANG;
      end
      S_ANG: begin
        cmd.ang    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/gtg_dp.sv]
// Datapath: offsets, square root, CORDIC bearing, ramp divider and command clamps.
module gtg_dp #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  gtg_pkg::dp_cmd_t   cmd,
  output gtg_pkg::dp_status_t status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] heading,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [14:0]        lin_cmd,
  output logic signed [15:0] ang_cmd,
  output logic               arrived
);
  import gtg_pkg::*;

  logic signed [31:0] goal_x, goal_y;
  logic [30:0]        tolerance;
  logic [15:0]        dist_gain, angle_gain, ramp_steps;
  logic [14:0]        speed_limit, turn_limit;
  logic [15:0]        ramp_count;

  logic [30:0]        ax, ay;
  logic               sh;
  logic signed [15:0] hd;
  logic [63:0]        sq;
  logic [33:0]        rem;
  logic [31:0]        root;
  logic signed [35:0] cx, cy, cz;
  logic [32:0]        distance;
  logic               arr;
  logic [32:0]        v;
  logic [15:0]        rc1;
  logic               ramped;
  logic [30:0]        num;
  logic [15:0]        drem;
  logic signed [15:0] e13;
  logic signed [19:0] ang_q;

  logic signed [32:0] dx, dy, adx, ady;
  logic               sh_c;
  logic [61:0]        axsq, aysq;
  logic [35:0]        rem_n, trial;
  logic signed [35:0] xs, ys, at;
  logic               cord_en;
  logic [32:0]        dist_c;
  logic [48:0]        vprod;
  logic               v_clamped;
  logic [16:0]        drn;
  logic signed [35:0] err_raw, err_w, err_r;
  logic signed [32:0] aprod;
  logic signed [19:0] a20, tl20;

  assign dx   = 33'(goal_x) - 33'(pos_x);
  assign dy   = 33'(goal_y) - 33'(pos_y);
  assign adx  = dx[32] ? -dx : dx;
  assign ady  = dy[32] ? -dy : dy;
  assign sh_c = adx[32] | adx[31] | ady[32] | ady[31];
  assign axsq = ax * ax;
  assign aysq = ay * ay;

  assign rem_n = {rem, sq[63:62]};
  assign trial = {2'b00, root, 2'b01};

  assign cord_en = ({1'b0, cmd.step} < 6'(CORDIC_ITERATIONS));
  assign xs      = cx >>> cmd.step;
  assign ys      = cy >>> cmd.step;
  assign at      = $signed({6'b0, atan_q30(cmd.step)});

  assign dist_c    = sh ? {root, 1'b0} : {1'b0, root};
  assign vprod     = distance * dist_gain;
  assign v_clamped = (v >= {18'b0, speed_limit});
  assign drn       = {drem, num[30]};

  assign err_raw = cz - (36'(hd) <<< 17);
  always_comb begin
    if (err_raw > PI_Q30) begin
      err_w = err_raw - TWO_PI_Q30;
    end else if (err_raw <= -PI_Q30) begin
      err_w = err_raw + TWO_PI_Q30;
    end else begin
      err_w = err_raw;
    end
  end
  assign err_r = (err_w + 36'sd65536) >>> 17;

  assign aprod = $signed({1'b0, angle_gain}) * e13;
  assign a20   = aprod[32:13];
  assign tl20  = $signed({5'b0, turn_limit});

  assign status.arrived = arr;
  assign status.ramp    = v_clamped && (rc1 < ramp_steps);

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x      <= '0;
      goal_y      <= '0;
      tolerance   <= 31'd6554;
      dist_gain   <= 16'd4096;
      angle_gain  <= 16'd4096;
      speed_limit <= 15'd4096;
      turn_limit  <= 15'd4096;
      ramp_steps  <= 16'd50;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GOAL_X:     goal_x      <= cfg_data;
        REG_GOAL_Y:     goal_y      <= cfg_data;
        REG_TOLERANCE:  tolerance   <= cfg_data[30:0];
        REG_DIST_GAIN:  dist_gain   <= cfg_data[15:0];
        REG_ANGLE_GAIN: angle_gain  <= cfg_data[15:0];
        REG_SPEED_LIM:  speed_limit <= cfg_data[14:0];
        REG_TURN_LIM:   turn_limit  <= cfg_data[14:0];
        REG_RAMP_STEPS: ramp_steps  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid  <= 1'b1;
        ramp_count <= arr ? 16'd0 : rc1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sh   <= sh_c;
      ax   <= sh_c ? adx[31:1] : adx[30:0];
      ay   <= sh_c ? ady[31:1] : ady[30:0];
      hd   <= heading;
      rem  <= '0;
      root <= '0;
      if (dx[32]) begin
        if (!dy[32]) begin
          cx <= 36'(dy);
          cy <= -36'(dx);
          cz <= HALF_PI_Q30;
        end else begin
          cx <= -36'(dy);
          cy <= 36'(dx);
          cz <= -HALF_PI_Q30;
        end
      end else begin
        cx <= 36'(dx);
        cy <= 36'(dy);
        cz <= '0;
      end
    end
    if (cmd.sq_x) begin
      sq <= 64'(axsq);
    end
    if (cmd.sq_y) begin
      sq <= sq + 64'(aysq);
    end
    if (cmd.root) begin
      sq <= {sq[61:0], 2'b00};
      if (rem_n >= trial) begin
        rem  <= 34'(rem_n - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_n[33:0];
        root <= {root[30:0], 1'b0};
      end
      if (cord_en) begin
        if (cy > 36'sd0) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end
      end
    end
    if (cmd.distance) begin
      distance <= dist_c;
      arr      <= (dist_c <= {2'b00, tolerance});
    end
    if (cmd.speed) begin
      v   <= vprod[48:16];
      rc1 <= (ramp_count == 16'hFFFF) ? ramp_count : ramp_count + 16'd1;
    end
    if (cmd.clamp) begin
      ramped <= status.ramp;
      if (v_clamped) begin
        v <= {18'b0, speed_limit};
      end
      num  <= 31'(speed_limit * rc1);
      drem <= '0;
    end
    if (cmd.div) begin
      if (drn >= {1'b0, ramp_steps}) begin
        drem <= 16'(drn - {1'b0, ramp_steps});
        num  <= {num[29:0], 1'b1};
      end else begin
        drem <= drn[15:0];
        num  <= {num[29:0], 1'b0};
      end
    end
    if (cmd.err) begin
      e13 <= err_r[15:0];
    end
    if (cmd.ang) begin
      ang_q <= a20;
    end
    if (cmd.finish) begin
      arrived <= arr;
      if (arr) begin
        lin_cmd <= '0;
        ang_cmd <= '0;
      end else begin
        lin_cmd <= ramped ? num[14:0] : v[14:0];
        if (ang_q > tl20) begin
          ang_cmd <= 16'(tl20);
        end else if (ang_q < -tl20) begin
          ang_cmd <= 16'(-tl20);
        end else begin
          ang_cmd <= ang_q[15:0];
        end
      end
    end
  end

endmodule

[rtl/go_to_goal_velocity_controller.sv]
// Top level of the go-to-goal velocity controller.
//   channel  direction  fields
//   pose     in         pos_x, pos_y, heading
//   result   out        lin_cmd, ang_cmd, arrived
//   cfg      in         index, data (register write)
// A sample passes through the squares, then the 32-step square root with the CORDIC run
// alongside it, then the distance check; unless arrived, the speed, the clamp, the 31-step
// ramp divider while the start-up ramp divides, the heading error and the angle follow.
// A new sample is taken only once the previous one has been worked through.
// A finished result waits in the output register while the next sample is worked;
// that sample is held back only if the earlier result has not yet been transferred.
// Reset is synchronous and restores the register defaults and clears the ramp count.
module go_to_goal_velocity_controller #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input logic          clk,
  input logic          rst,
  gtg_pose_if.sink     pose,
  gtg_result_if.source result,
  gtg_cfg_if.sink      cfg
);
  import gtg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign pose.ready = in_ready;
  assign cfg.ready  = 1'b1;

  gtg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pose.valid),
    .in_ready (in_ready),
    .out_free (!result.valid || result.ready),
    .status   (status),
    .cmd      (cmd)
  );

  gtg_dp #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .pos_x     (pose.pos_x),
    .pos_y     (pose.pos_y),
    .heading   (pose.heading),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .lin_cmd   (result.lin_cmd),
    .ang_cmd   (result.ang_cmd),
    .arrived   (result.arrived)
  );

endmodule

[tb/gtg_checker.sv]
// Checker for the go-to-goal controller: tracks registers, predicts commands and compares them.
module gtg_checker
  import gtg_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  gtg_pose_if    pose,
  gtg_result_if  result,
  gtg_cfg_if     cfg,
  output int     errors,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [14:0]        lin_cmd;
    logic signed [15:0] ang_cmd;
    logic               arrived;
  } vel_cmd_t;

  localparam int CORDIC_STEPS = 16;

  longint          goal_x, goal_y;
  longint unsigned tolerance, dist_gain, angle_gain;
  longint unsigned speed_limit, turn_limit, ramp_steps, ramp_count;
  vel_cmd_t        expected_cmds[$];

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint bearing(longint x, longint y);
    longint z;
    longint t;
    longint xs;
    longint ys;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = HALF_PI_Q30;
      end else begin
        x = -y;
        y = t;
        z = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_q30(i[4:0]));
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_q30(i[4:0]));
      end
    end
    return z;
  endfunction

  function automatic vel_cmd_t steer_to_goal(logic signed [31:0] px, logic signed [31:0] py,
                                             logic signed [15:0] hd);
    vel_cmd_t        c;
    longint          dx, dy, err, e13, ang, tl;
    longint unsigned ax, ay, distance, v;
    int              sh;
    dx = goal_x - longint'(px);
    dy = goal_y - longint'(py);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sh = (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) ? 1 : 0;
    ax = ax >> sh;
    ay = ay >> sh;
    distance = int_sqrt(ax * ax + ay * ay) << sh;
    if (distance <= tolerance) begin
      ramp_count = 0;
      c.lin_cmd = '0;
      c.ang_cmd = '0;
      c.arrived = 1'b1;
      return c;
    end
    if (ramp_count < 65535) ramp_count++;
    v = (distance * dist_gain) >> 16;
    if (v >= speed_limit) begin
      v = speed_limit;
      if (ramp_count < ramp_steps) v = (v * ramp_count) / ramp_steps;
    end
    err = bearing(dx, dy) - longint'(hd) * 131072;
    if (err > PI_Q30) err = err - TWO_PI_Q30;
    else if (err <= -PI_Q30) err = err + TWO_PI_Q30;
    e13 = (err + 65536) >>> 17;
    ang = (longint'(angle_gain) * e13) >>> 13;
    tl = longint'(turn_limit);
    if (ang > tl) ang = tl;
    if (ang < -tl) ang = -tl;
    c.lin_cmd = v[14:0];
    c.ang_cmd = ang[15:0];
    c.arrived = 1'b0;
    return c;
  endfunction

  always @(posedge clk) begin
    vel_cmd_t exp_c;
    if (rst) begin
      goal_x      = 0;
      goal_y      = 0;
      tolerance   = 6554;
      dist_gain   = 4096;
      angle_gain  = 4096;
      speed_limit = 4096;
      turn_limit  = 4096;
      ramp_steps  = 50;
      ramp_count  = 0;
      errors      = 0;
      expected_cmds.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_t'(cfg.index))
          REG_GOAL_X:     goal_x = longint'($signed(cfg.data));
          REG_GOAL_Y:     goal_y = longint'($signed(cfg.data));
          REG_TOLERANCE:  tolerance = cfg.data[30:0];
          REG_DIST_GAIN:  dist_gain = cfg.data[15:0];
          REG_ANGLE_GAIN: angle_gain = cfg.data[15:0];
          REG_SPEED_LIM:  speed_limit = cfg.data[14:0];
          REG_TURN_LIM:   turn_limit = cfg.data[14:0];
          REG_RAMP_STEPS: ramp_steps = cfg.data[15:0];
          default: ;
        endcase
      end
      if (pose.valid && pose.ready)
        expected_cmds.push_back(steer_to_goal(pose.pos_x, pose.pos_y, pose.heading));
      if (result.valid && result.ready) begin
        if (expected_cmds.size() == 0) begin
          $error("Result transfer with no command expected");
          errors++;
        end else begin
          exp_c = expected_cmds.pop_front();
          if (result.lin_cmd !== exp_c.lin_cmd) begin
            $error("lin_cmd: expected %0d, got %0d", exp_c.lin_cmd, result.lin_cmd);
            errors++;
          end
          if (result.ang_cmd !== exp_c.ang_cmd) begin
            $error("ang_cmd: expected %0d, got %0d", exp_c.ang_cmd, result.ang_cmd);
            errors++;
          end
          if (result.arrived !== exp_c.arrived) begin
            $error("arrived: expected %0b, got %0b", exp_c.arrived, result.arrived);
            errors++;
          end
        end
      end
    end
    pending = expected_cmds.size();
  end

endmodule

[tb/go_to_goal_velocity_controller_test.sv]
// Top of the go-to-goal controller testbench: clock, reset, stimulus and verdict.
module go_to_goal_velocity_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gtg_pkg::*;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   stall_pct = 0;
  int   burst_left;

  logic signed [31:0] goal_x, goal_y;
  logic [30:0]        tolerance;

  gtg_pose_if   pose();
  gtg_result_if result();
  gtg_cfg_if    cfg();

  go_to_goal_velocity_controller uut (
    .clk(clk), .rst(rst), .pose(pose), .result(result), .cfg(cfg)
  );

  gtg_checker checker_i (
    .clk(clk), .rst(rst), .pose(pose), .result(result), .cfg(cfg),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // The receiver changes its stall rate at random moments, including spells with none.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 70;
        default: stall_pct = 95;
      endcase
    end
    result.ready = ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value, int width);
    logic [31:0] mask;
    mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 1);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = (value & mask) | ($urandom & ~mask);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic configure(logic signed [31:0] gx, logic signed [31:0] gy, logic [30:0] tol,
                           logic [15:0] dg, logic [15:0] ag, logic [14:0] sl,
                           logic [14:0] tl, logic [15:0] rs);
    drain();
    write_reg(REG_GOAL_X, gx, 32);
    write_reg(REG_GOAL_Y, gy, 32);
    write_reg(REG_TOLERANCE, tol, 31);
    write_reg(REG_DIST_GAIN, dg, 16);
    write_reg(REG_ANGLE_GAIN, ag, 16);
    write_reg(REG_SPEED_LIM, sl, 15);
    write_reg(REG_TURN_LIM, tl, 15);
    write_reg(REG_RAMP_STEPS, rs, 16);
    goal_x    = gx;
    goal_y    = gy;
    tolerance = tol;
  endtask

  // Called at a falling edge; returns at a falling edge after the transfer, possibly after an idle gap.
  task automatic send_pose(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [15:0] hd);
    pose.valid   = 1'b1;
    pose.pos_x   = x;
    pose.pos_y   = y;
    pose.heading = hd;
    @(posedge clk);
    while (!pose.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pose.valid = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 20)) @(negedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic send_random_pose;
    longint           off_x, off_y;
    int               s;
    logic signed [15:0] hd;
    hd = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 51472) - 25736);
    case ($urandom_range(0, 9))
      0: begin
        send_pose($urandom, $urandom, hd);
        return;
      end
      1: begin
        off_x = longint'(tolerance) / 2 - longint'($urandom_range(0, 3000));
        off_y = longint'($urandom_range(0, 1000));
      end
      default: begin
        s = $urandom_range(4, 31);
        off_x = longint'($signed($urandom)) >>> (31 - s);
        off_y = longint'($signed($urandom)) >>> (31 - s);
      end
    endcase
    send_pose(32'(goal_x - off_x), 32'(goal_y - off_y), hd);
  endtask

  task automatic random_phase(int n);
    logic [15:0] rs;
    rs = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 20)) : 16'($urandom);
    configure($urandom, $urandom, 31'($urandom_range(0, 20000)),
              16'($urandom_range(0, 16384)), 16'($urandom_range(0, 65535)),
              15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)), rs);
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        pose.valid = 1'b0;
        drain();
      end
      send_random_pose();
    end
    pose.valid = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    burst_left   = 0;
    goal_x       = 0;
    goal_y       = 0;
    tolerance    = 6554;
    pose.valid   = 1'b0;
    pose.pos_x   = '0;
    pose.pos_y   = '0;
    pose.heading = '0;
    cfg.valid    = 1'b0;
    cfg.index    = REG_GOAL_X;
    cfg.data     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default registers: zero offset, extremes, quadrant changes and heading beyond pi.
    send_pose(0, 0, 0);
    send_pose(6554, 0, 16'sd25736);
    send_pose(6555, 0, -16'sd25736);
    send_pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF);
    send_pose(32'sh8000_0000, 32'sh8000_0000, 16'sh8000);
    send_pose(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    send_pose(32'sh7FFF_FFFF, 0, 16'sd25736);
    send_pose(32'sh7FFF_FFFF, -32'sd1, -16'sd25736);
    send_pose(0, 32'sh0010_0000, 0);
    send_pose(0, -32'sh0010_0000, 16'sd12868);
    for (int i = 0; i < 6; i++) send_pose(32'sh0100_0000, 32'sh0080_0000, 16'($urandom));
    pose.valid = 1'b0;

    // Largest gains and limits, then the smallest with no ramp.
    configure(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF,
              16'hFFFF);
    @(negedge clk);
    send_pose(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    send_pose(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF);
    send_pose(32'sh8000_0001, 32'sh7FFF_FFFF, 16'sh8000);
    send_pose(0, 0, 0);
    pose.valid = 1'b0;
    configure(0, 0, 31'h7FFF_FFFF, 0, 0, 0, 0, 0);
    @(negedge clk);
    send_pose(32'sh8000_0000, 32'sh8000_0000, 0);
    send_pose(32'sh0000_1000, 0, 0);
    pose.valid = 1'b0;
    configure(0, 0, 1, 0, 0, 0, 0, 0);
    @(negedge clk);
    send_pose(32'sh8000_0000, 32'sh8000_0000, 16'sh7FFF);
    send_pose(32'sh7FFF_FFFF, 32'sh0, 16'sh8000);
    send_pose(32'sh0, 32'sh1, 0);
    pose.valid = 1'b0;

    for (int p = 0; p < 6; p++) random_phase(80);

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[go_to_goal_velocity_controller.f]
rtl/gtg_pkg.sv
rtl/gtg_pose_if.sv
rtl/gtg_result_if.sv
rtl/gtg_cfg_if.sv
rtl/gtg_ctrl.sv
rtl/gtg_dp.sv
rtl/go_to_goal_velocity_controller.sv
tb/gtg_checker.sv
tb/go_to_goal_velocity_controller_test.sv
